// ===== hw/rtl/porr_pkg.sv =====
// ----------------------------------------------------------------------------
// porr_pkg: shared types and constants for the priority ring registry
// Field widths, command and status codes, sequencer states and default
// sizing for the registry core and its checker.
// ----------------------------------------------------------------------------
package porr_pkg;

  // default sizing
  localparam int MAX_ENTRIES_DEF   = 16;
  localparam int ID_BITS_DEF       = 8;
  localparam int PRIORITY_BITS_DEF = 8;

  // port field widths
  localparam int CMD_W    = 1;
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_REGISTER = 1'b0;
  localparam logic [CMD_W-1:0] CMD_NEXT     = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_NXT,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/porr_ram.sv =====
// ----------------------------------------------------------------------------
// porr_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module porr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/priority_ordered_ring_registry_core.sv =====
// ----------------------------------------------------------------------------
// priority_ordered_ring_registry_core: priority-sorted handler ring
// Keeps registered handlers in descending priority order in a RAM and hands
// them out round robin from a start pointer that tracks its entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transfer carries a command.
//   CMD_REGISTER inserts in_handler_id/in_handler_priority ahead of the first
//   entry of equal or lower priority; CMD_NEXT returns the entry under the
//   start pointer. Every command yields exactly one result transfer on the
//   output channel (out_valid/out_ready) with status, id and priority.
//   Timing: one command is in flight at a time. A register walks the table
//   from the tail, one entry per cycle through the single RAM read port,
//   shifting each entry of equal or lower priority up one slot as it goes,
//   then writes the new entry in the place step. A full-table register or an
//   empty-table next goes straight to the emit step; a successful next reads
//   the entry under the start pointer through the registered RAM read port.
//   Reset: table count, start pointer and its set flag clear; the RAM is
//   not cleared, since only slots below the count are ever read.
//   Stall: the result sits in an output register; the core goes back to
//   idle and takes a new command while it waits. A second result waits in
//   the emit step until the output register frees up.
// ----------------------------------------------------------------------------
module priority_ordered_ring_registry_core #(
  parameter int MAX_ENTRIES   = porr_pkg::MAX_ENTRIES_DEF,
  parameter int ID_BITS       = porr_pkg::ID_BITS_DEF,
  parameter int PRIORITY_BITS = porr_pkg::PRIORITY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [porr_pkg::CMD_W-1:0]    in_cmd,
  input  logic [porr_pkg::ID_W-1:0]     in_handler_id,
  input  logic [porr_pkg::PRIO_W-1:0]   in_handler_priority,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [porr_pkg::STATUS_W-1:0] out_status,
  output logic [porr_pkg::ID_W-1:0]     out_chosen_id,
  output logic [porr_pkg::PRIO_W-1:0]   out_chosen_priority
);

  import porr_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = ID_BITS + PRIORITY_BITS;

  // sequencer and table control
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic               set_r, set_nxt;
  logic               out_valid_r, out_valid_nxt;

  // per-command working registers
  logic [IDX_W-1:0]         k_r, k_nxt;       // entry under compare
  logic [IDX_W-1:0]         pos_r, pos_nxt;   // insert slot / read slot
  logic [ID_BITS-1:0]       new_id_r, new_id_nxt;
  logic [PRIORITY_BITS-1:0] new_prio_r, new_prio_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [ID_W-1:0]          res_id_r, res_id_nxt;
  logic [PRIO_W-1:0]        res_prio_r, res_prio_nxt;

  // output register
  status_t                  out_status_r, out_status_nxt;
  logic [ID_W-1:0]          out_id_r, out_id_nxt;
  logic [PRIO_W-1:0]        out_prio_r, out_prio_nxt;

  // RAM port
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENT_W-1:0]         ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENT_W-1:0]         ram_rdata;

  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [ID_BITS-1:0]       rd_id;
  logic [CNT_W-1:0]         wrap_pos;
  logic [IDX_W-1:0]         sel_pos;

  // entry layout: {id, priority}
  porr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_prio  = ram_rdata[PRIORITY_BITS-1:0];
  assign rd_id    = ram_rdata[ENT_W-1:PRIORITY_BITS];
  assign wrap_pos = CNT_W'(pos_r) + 1'b1;
  // a stale pointer (at or past the count) reads the head
  assign sel_pos  = (!set_r || (CNT_W'(ptr_r) >= count_r)) ? '0 : ptr_r;

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_chosen_id       = out_id_r;
  assign out_chosen_priority = out_prio_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    set_nxt        = set_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    new_id_nxt     = new_id_r;
    new_prio_nxt   = new_prio_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_prio_nxt   = res_prio_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_valid_nxt  = out_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    // result taken by the receiver
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_id_nxt   = ID_BITS'(in_handler_id);
          new_prio_nxt = PRIORITY_BITS'(in_handler_priority);
          res_id_nxt   = '0;
          res_prio_nxt = '0;
          if (in_cmd == CMD_REGISTER) begin
            if (count_r == CNT_W'(MAX_ENTRIES)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_EMIT;
            end else if (count_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_PLACE;
            end else begin
              // start the walk at the tail
              k_nxt     = IDX_W'(count_r - 1'b1);
              ram_raddr = IDX_W'(count_r - 1'b1);
              state_nxt = S_CMP;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              ram_raddr = sel_pos;
              pos_nxt   = sel_pos;
              state_nxt = S_NXT;
            end
          end
        end
      end

      S_CMP: begin
        if (rd_prio > new_prio_r) begin
          pos_nxt   = k_r + 1'b1;
          state_nxt = S_PLACE;
        end else begin
          // shift this entry up one slot and keep walking toward the head
          ram_we    = 1'b1;
          ram_waddr = k_r + 1'b1;
          ram_wdata = ram_rdata;
          if (k_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_PLACE;
          end else begin
            k_nxt     = k_r - 1'b1;
            ram_raddr = k_r - 1'b1;
          end
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = {new_id_r, new_prio_r};
        count_nxt = count_r + 1'b1;
        // pointer follows its entry when the insert lands at or before it
        if (set_r && (ptr_r >= pos_r)) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        res_status_nxt = ST_OK;
        state_nxt      = S_EMIT;
      end

      S_NXT: begin
        res_status_nxt = ST_OK;
        res_id_nxt     = ID_W'(rd_id);
        res_prio_nxt   = PRIO_W'(rd_prio);
        if (!set_r) begin
          // first next: park on the head, no advance
          set_nxt = 1'b1;
          ptr_nxt = '0;
        end else if (wrap_pos >= count_r) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = IDX_W'(wrap_pos);
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_prio_nxt   = res_prio_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      set_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      set_r       <= set_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    pos_r        <= pos_nxt;
    new_id_r     <= new_id_nxt;
    new_prio_r   <= new_prio_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_prio_r   <= res_prio_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_prio_r   <= out_prio_nxt;
  end

endmodule

// ===== hw/rtl/porr_checker.sv =====
// ----------------------------------------------------------------------------
// porr_checker: port-level checks for the priority ring registry
// Watches the core's ports; attached to the core by bind.
// ----------------------------------------------------------------------------
module porr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [porr_pkg::CMD_W-1:0]    in_cmd,
  input logic [porr_pkg::ID_W-1:0]     in_handler_id,
  input logic [porr_pkg::PRIO_W-1:0]   in_handler_priority,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [porr_pkg::STATUS_W-1:0] out_status,
  input logic [porr_pkg::ID_W-1:0]     out_chosen_id,
  input logic [porr_pkg::PRIO_W-1:0]   out_chosen_priority
);

  import porr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_chosen_id) &&
       $stable(out_chosen_priority)))
    else $error("result changed while stalled");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_EMPTY ||
                   out_status == ST_FULL))
    else $error("undefined status code");

  // error results carry no handler
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_chosen_id == '0 && out_chosen_priority == '0))
    else $error("error result with nonzero handler");

  // one command in flight: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_valid && in_ready) |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a waiting command holds its payload until the transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_cmd) && $stable(in_handler_id) &&
       $stable(in_handler_priority)))
    else $error("command changed while waiting");

endmodule

bind priority_ordered_ring_registry_core porr_checker u_porr_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for priority_ordered_ring_registry_core
// Drives register and next commands over the valid/ready input channel and
// checks every result transfer against a cycle-free model of the sorted ring
// and its rotating start pointer. Directed cases come first, then random
// traffic under several idle and stall mixes, and a full-table case last.
// ----------------------------------------------------------------------------
module tb_top;
  import porr_pkg::*;

  localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
  // Longest run of cycles with no transfer on either channel before the run
  // is declared hung. The longest register walk and the random idle and
  // stall runs are short next to this, so the limit is generous.
  localparam int HANG_LIMIT  = 4000;
  // Cycles to keep watching after the last expected result: covers one more
  // full-length insert in case the core emits something it should not.
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;

  // one result transfer
  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
  } registry_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd = CMD_REGISTER;
  logic [ID_W-1:0]     in_handler_id = '0;
  logic [PRIO_W-1:0]   in_handler_priority = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_chosen_id;
  logic [PRIO_W-1:0]   out_chosen_priority;

  // Percent chance per cycle that the sender holds off / the receiver stalls.
  int send_idle_pct = 0;
  int out_stall_pct = 0;

  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Shadow copy of the registry: sorted table, fill count, start pointer.
  logic [ID_W-1:0]   tbl_ids   [MAX_ENTRIES];
  logic [PRIO_W-1:0] tbl_prios [MAX_ENTRIES];
  int                tbl_count = 0;
  int                ring_ptr = 0;
  bit                ring_ptr_valid = 1'b0;

  // Results still owed by the core, oldest first.
  registry_result_t pending_results[$];
  registry_result_t want_result;

  priority_ordered_ring_registry_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_handler_id       (in_handler_id),
    .in_handler_priority (in_handler_priority),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_chosen_id       (out_chosen_id),
    .out_chosen_priority (out_chosen_priority)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of one command. Updates the shadow table and returns the result.
  // --------------------------------------------------------------------------
  function automatic registry_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [PRIO_W-1:0] prio);
    registry_result_t r;
    int pos;
    r.status = ST_OK;
    r.id     = '0;
    r.prio   = '0;
    if (cmd == CMD_REGISTER) begin
      if (tbl_count >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes ahead of the first one with equal or lower priority
        pos = 0;
        while (pos < tbl_count && tbl_prios[pos] > prio) pos++;
        for (int k = tbl_count; k > pos; k--) begin
          tbl_ids[k]   = tbl_ids[k-1];
          tbl_prios[k] = tbl_prios[k-1];
        end
        tbl_ids[pos]   = id;
        tbl_prios[pos] = prio;
        tbl_count++;
        // pointer follows its entry when the insert shifts it
        if (ring_ptr_valid && ring_ptr >= pos) ring_ptr++;
      end
    end else if (tbl_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      if (ring_ptr >= tbl_count) ring_ptr = 0;
      if (!ring_ptr_valid) begin
        // first next: land on the head, do not advance
        ring_ptr_valid = 1'b1;
        ring_ptr = 0;
        r.id   = tbl_ids[0];
        r.prio = tbl_prios[0];
      end else begin
        r.id   = tbl_ids[ring_ptr];
        r.prio = tbl_prios[ring_ptr];
        ring_ptr++;
        if (ring_ptr >= tbl_count) ring_ptr = 0;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Send one command. Entered and left at a falling edge. Optional idle
  // cycles first, then valid stays up with a fixed payload until the transfer.
  // The expectation is queued at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_cmd              = cmd;
    in_handler_id       = id;
    in_handler_priority = prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_command(cmd, id, prio));
    @(negedge clk);
  endtask

  // Random register; a quarter of them reuse a priority already held so that
  // ties against existing entries come up often.
  task automatic send_random_register();
    logic [PRIO_W-1:0] prio;
    prio = PRIO_W'($urandom_range(0, 255));
    if (tbl_count > 0 && $urandom_range(0, 3) == 0)
      prio = tbl_prios[$urandom_range(0, tbl_count - 1)];
    send_command(CMD_REGISTER, ID_W'($urandom_range(0, 255)), prio);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // next with nothing registered; id/priority bits must be ignored
  task automatic test_empty_table();
    send_command(CMD_NEXT, 8'hFF, 8'hFF);
    send_command(CMD_NEXT, 8'h00, 8'h00);
  endtask

  // extremes of id and priority, ties at the top, middle and bottom
  task automatic test_register_order();
    send_command(CMD_REGISTER, 8'h00, 8'h00);
    send_command(CMD_REGISTER, 8'hFF, 8'hFF);
    send_command(CMD_REGISTER, 8'h5A, 8'h80);
    send_command(CMD_REGISTER, 8'hA5, 8'h80);
    send_command(CMD_REGISTER, 8'h01, 8'hFF);
    send_command(CMD_REGISTER, 8'h02, 8'h00);
  endtask

  // first next returns the head without moving; later ones advance
  task automatic test_first_next();
    repeat (3) send_command(CMD_NEXT, ID_W'($urandom_range(0, 255)),
                            PRIO_W'($urandom_range(0, 255)));
  endtask

  // inserts before and after the pointer, each followed by a next
  task automatic test_pointer_tracking();
    send_command(CMD_REGISTER, 8'h33, 8'hC0);
    send_command(CMD_NEXT, 8'h00, 8'h00);
    send_command(CMD_REGISTER, 8'h44, 8'h10);
    send_command(CMD_NEXT, 8'hFF, 8'hFF);
  endtask

  // walk once around the ring and past the tail
  task automatic test_ring_wrap();
    int laps;
    laps = tbl_count + 1;
    repeat (laps) send_command(CMD_NEXT, ID_W'($urandom_range(0, 255)),
                               PRIO_W'($urandom_range(0, 255)));
  endtask

  // fill whatever is left, register against a full table twice, then one next
  task automatic test_full_table();
    while (tbl_count < MAX_ENTRIES) send_random_register();
    send_command(CMD_REGISTER, 8'hFF, 8'hFF);
    send_command(CMD_REGISTER, 8'h00, 8'h00);
    send_command(CMD_NEXT, 8'h00, 8'h00);
  endtask

  // Random mix under one idle/stall setting. Registers are kept to about one
  // in five so the table fills gradually with nexts interleaved, and the
  // pointer gets shifted by inserts from many positions.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 20)
        send_random_register();
      else
        send_command(CMD_NEXT, ID_W'($urandom_range(0, 255)),
                     PRIO_W'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready toggles at the falling edge per the current stall mix.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker: every output transfer against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d id %0h priority %0h",
                 $time, out_status, out_chosen_id, out_chosen_priority);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (want_result.status !== out_status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, want_result.status, out_status);
          mismatch_count++;
        end
        if (want_result.id !== out_chosen_id) begin
          $display("%0t: chosen_id mismatch expected %0h actual %0h",
                   $time, want_result.id, out_chosen_id);
          mismatch_count++;
        end
        if (want_result.prio !== out_chosen_priority) begin
          $display("%0t: chosen_priority mismatch expected %0h actual %0h",
                   $time, want_result.prio, out_chosen_priority);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Hang watchdog: cycles with no transfer on either channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // synchronous reset held low from the start, released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, no idling
    test_empty_table();
    test_register_order();
    test_first_next();
    test_pointer_tracking();
    test_ring_wrap();

    // random part: clean, sender idle, receiver stall, both
    test_random_traffic(185, 0, 0);
    test_random_traffic(185, 54, 0);
    test_random_traffic(185, 0, 54);
    test_random_traffic(185, 28, 28);

    test_full_table();

    in_valid = 1'b0;
    out_stall_pct = 0;

    // drain, then watch a while longer for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/porr_pkg.sv
hw/rtl/porr_ram.sv
hw/rtl/priority_ordered_ring_registry_core.sv
hw/rtl/porr_checker.sv
dv/tb_top.sv
